/* sv/rcc_pkg.sv */
// ---------------------------------------------------------------------------
// rcc_pkg
// Shared widths, register indexes and transaction types for the ray / cylinder
// cap intersection pipeline.
// ---------------------------------------------------------------------------
package rcc_pkg;

  localparam int CRD_W     = 32;   // Q16.16 coordinate
  localparam int DIR_W     = 18;   // Q2.16 unit vector component
  localparam int NRM_W     = 19;   // cap normal, holds the negated axis
  localparam int CTR_W     = 34;   // cap centre, far cap adds axis * height
  localparam int DIF_W     = 35;   // centre minus origin
  localparam int DEN_W     = 21;   // |n . d| in Q5.16
  localparam int NUM_W     = 53;   // |(c - o) . n| in Q21.32
  localparam int QUO_W     = 40;   // quotient bits below the clamp
  localparam int PNT_W     = 44;   // wide hit point
  localparam int T_W       = 31;
  localparam int RAD_W     = 31;
  localparam int R2_W      = 62;
  localparam int EPS_W     = 16;
  localparam int IDX_W     = 3;
  localparam int CFG_W     = 32;

  localparam int DIV_STAGES = QUO_W + 1;
  localparam int FRONT_LAT  = 3;
  localparam int RAY_DLY    = FRONT_LAT + DIV_STAGES;

  localparam logic [IDX_W-1:0] REG_BASE_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_BASE_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_BASE_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_AXIS_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_AXIS_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_AXIS_Z = 3'd5;
  localparam logic [IDX_W-1:0] REG_RADIUS = 3'd6;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd7;

  localparam logic [T_W-1:0] T_SAT = {T_W{1'b1}};

  typedef struct packed {
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [CRD_W-1:0] z;
  } vec_crd_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] x;
    logic signed [DIR_W-1:0] y;
    logic signed [DIR_W-1:0] z;
  } vec_dir_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] x;
    logic signed [NRM_W-1:0] y;
    logic signed [NRM_W-1:0] z;
  } vec_nrm_t;

  typedef struct packed {
    logic signed [CTR_W-1:0] x;
    logic signed [CTR_W-1:0] y;
    logic signed [CTR_W-1:0] z;
  } vec_ctr_t;

  typedef struct packed {
    vec_crd_t o;
    vec_dir_t d;
  } ray_t;

  typedef struct packed {
    logic             vld;
    logic             ok;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             vld;
    logic             ok;
    logic             ov;
    logic [QUO_W-1:0] q;
  } div_rsp_t;

  typedef struct packed {
    logic           vld;
    logic           hit;
    logic [T_W-1:0] t;
    vec_crd_t       p;
  } cap_res_t;

endpackage

/* sv/rcc_ray_if.sv */
// ---------------------------------------------------------------------------
// rcc_ray_if
// Ray channel: origin and unit direction, valid / ready.
// ---------------------------------------------------------------------------
interface rcc_ray_if import rcc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [CRD_W-1:0] origin_x;
  logic signed [CRD_W-1:0] origin_y;
  logic signed [CRD_W-1:0] origin_z;
  logic signed [DIR_W-1:0] dir_x;
  logic signed [DIR_W-1:0] dir_y;
  logic signed [DIR_W-1:0] dir_z;

  modport source(output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 input ready);
  modport sink(input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               output ready);
endinterface

/* sv/rcc_res_if.sv */
// ---------------------------------------------------------------------------
// rcc_res_if
// Result channel: hit flag, cap select, ray parameter and hit point.
// ---------------------------------------------------------------------------
interface rcc_res_if import rcc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic                    which_cap;
  logic [T_W-1:0]          hit_t;
  logic signed [CRD_W-1:0] point_x;
  logic signed [CRD_W-1:0] point_y;
  logic signed [CRD_W-1:0] point_z;

  modport source(output valid, hit, which_cap, hit_t, point_x, point_y, point_z,
                 input ready);
  modport sink(input valid, hit, which_cap, hit_t, point_x, point_y, point_z,
               output ready);
endinterface

/* sv/rcc_cap_front.sv */
// ---------------------------------------------------------------------------
// rcc_cap_front
// Plane setup for one cap: denominator n . d, numerator (c - o) . n and the
// epsilon / sign checks, three register stages.
// ---------------------------------------------------------------------------
module rcc_cap_front import rcc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_in,
  input  ray_t             ray,
  input  vec_nrm_t         nrm,
  input  vec_ctr_t         ctr,
  input  logic [EPS_W-1:0] eps,
  output div_req_t         req
);

  logic signed [NRM_W-1:0]       n_v [3];
  logic signed [DIR_W-1:0]       d_v [3];
  logic signed [CRD_W-1:0]       o_v [3];
  logic signed [CTR_W-1:0]       c_v [3];

  logic signed [NRM_W+DIR_W-1:0] pd_a_r  [3];
  logic signed [DIF_W-1:0]       dif_a_r [3];
  logic                          vld_a_r;

  logic signed [NRM_W+DIR_W+1:0] den_sum;
  logic signed [DEN_W:0]         den_b_r;
  logic signed [DIF_W+NRM_W-1:0] np_b_r [3];
  logic                          vld_b_r;

  logic signed [DIF_W+NRM_W+1:0] num_sum;
  logic [DIF_W+NRM_W+1:0]        num_mag;
  logic [DEN_W:0]                den_mag;
  logic                          ok_nxt;
  div_req_t                      req_r;

  always_comb begin
    n_v[0] = nrm.x;  n_v[1] = nrm.y;  n_v[2] = nrm.z;
    d_v[0] = ray.d.x; d_v[1] = ray.d.y; d_v[2] = ray.d.z;
    o_v[0] = ray.o.x; o_v[1] = ray.o.y; o_v[2] = ray.o.z;
    c_v[0] = ctr.x;  c_v[1] = ctr.y;  c_v[2] = ctr.z;
  end

  // stage a: direction products and centre offset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= vld_in;
      for (int i = 0; i < 3; i++) begin
        pd_a_r[i]  <= n_v[i] * d_v[i];
        dif_a_r[i] <= DIF_W'(c_v[i]) - DIF_W'(o_v[i]);
      end
    end
  end

  // stage b: floored denominator and numerator products
  assign den_sum = (NRM_W+DIR_W+2)'(pd_a_r[0]) + (NRM_W+DIR_W+2)'(pd_a_r[1])
                 + (NRM_W+DIR_W+2)'(pd_a_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else if (en) begin
      vld_b_r <= vld_a_r;
      den_b_r <= den_sum[DEN_W+16:16];
      for (int i = 0; i < 3; i++) begin
        np_b_r[i] <= dif_a_r[i] * n_v[i];
      end
    end
  end

  // stage c: magnitudes and the plane checks
  always_comb begin
    num_sum = (DIF_W+NRM_W+2)'(np_b_r[0]) + (DIF_W+NRM_W+2)'(np_b_r[1])
            + (DIF_W+NRM_W+2)'(np_b_r[2]);
    num_mag = num_sum[DIF_W+NRM_W+1] ? (DIF_W+NRM_W+2)'(-num_sum)
                                      : (DIF_W+NRM_W+2)'(num_sum);
    den_mag = den_b_r[DEN_W] ? (DEN_W+1)'(-den_b_r) : (DEN_W+1)'(den_b_r);
    // t >= 0 when the numerator is zero or shares the denominator's sign
    ok_nxt  = (den_mag > (DEN_W+1)'(eps)) &&
              ((num_sum == '0) || (num_sum[DIF_W+NRM_W+1] == den_b_r[DEN_W]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r.vld <= 1'b0;
    end else if (en) begin
      req_r.vld <= vld_b_r;
      req_r.ok  <= ok_nxt;
      req_r.num <= num_mag[NUM_W-1:0];
      req_r.den <= den_mag[DEN_W-1:0];
    end
  end

  assign req = req_r;

endmodule

/* sv/rcc_div.sv */
// ---------------------------------------------------------------------------
// rcc_div
// Pipelined restoring divider, one quotient bit per stage, with a first stage
// that flags quotients of 2^40 and above.
// ---------------------------------------------------------------------------
module rcc_div import rcc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CMP_W = DEN_W + QUO_W;

  typedef struct packed {
    logic             vld;
    logic             ok;
    logic             ov;
    logic [NUM_W-1:0] rem;
    logic [QUO_W-1:0] q;
    logic [DEN_W-1:0] den;
  } div_stg_t;

  div_stg_t stg_r [DIV_STAGES];
  div_stg_t stg0_nxt;

  always_comb begin
    stg0_nxt.vld = req.vld;
    stg0_nxt.ok  = req.ok;
    stg0_nxt.ov  = CMP_W'(req.num) >= {req.den, {QUO_W{1'b0}}};
    stg0_nxt.rem = req.num;
    stg0_nxt.q   = '0;
    stg0_nxt.den = req.den;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r[0].vld <= 1'b0;
    end else if (en) begin
      stg_r[0] <= stg0_nxt;
    end
  end

  for (genvar i = 1; i < DIV_STAGES; i++) begin : g_stg
    localparam int BIT = QUO_W - i;
    logic [CMP_W-1:0] trial;
    logic             ge;
    div_stg_t         stg_nxt;

    always_comb begin
      trial   = CMP_W'(stg_r[i-1].den) << BIT;
      ge      = CMP_W'(stg_r[i-1].rem) >= trial;
      stg_nxt = stg_r[i-1];
      if (ge) begin
        stg_nxt.rem = stg_r[i-1].rem - trial[NUM_W-1:0];
      end
      stg_nxt.q[BIT] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_r[i].vld <= 1'b0;
      end else if (en) begin
        stg_r[i] <= stg_nxt;
      end
    end
  end

  assign rsp.vld = stg_r[DIV_STAGES-1].vld;
  assign rsp.ok  = stg_r[DIV_STAGES-1].ok;
  assign rsp.ov  = stg_r[DIV_STAGES-1].ov;
  assign rsp.q   = stg_r[DIV_STAGES-1].q;

endmodule

/* sv/rcc_cap_back.sv */
// ---------------------------------------------------------------------------
// rcc_cap_back
// Hit point from the clamped t and the disk test against the cap radius,
// four register stages.
// ---------------------------------------------------------------------------
module rcc_cap_back import rcc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  div_rsp_t         rsp,
  input  ray_t             ray,
  input  vec_ctr_t         ctr,
  input  logic [RAD_W-1:0] radius,
  input  logic [R2_W-1:0]  r2,
  output cap_res_t         res
);

  localparam int TI_W = QUO_W + 1;
  localparam int PR_W = DIR_W + TI_W;

  function automatic logic signed [CRD_W-1:0] sat_crd(input logic signed [PNT_W-1:0] v);
    logic [PNT_W-CRD_W:0] top;
    top = v[PNT_W-1:CRD_W-1];
    if ((&top) || !(|top)) begin
      return v[CRD_W-1:0];
    end
    return v[PNT_W-1] ? {1'b1, {(CRD_W-1){1'b0}}} : {1'b0, {(CRD_W-1){1'b1}}};
  endfunction

  logic signed [DIR_W-1:0] d_v [3];
  logic signed [CTR_W-1:0] c_v [3];
  logic signed [TI_W-1:0]  ti;
  logic [T_W-1:0]          t_nxt;

  logic signed [PR_W-1:0]  prod_1_r [3];
  vec_crd_t                o_1_r;
  logic [T_W-1:0]          t_1_r;
  logic                    ok_1_r;
  logic                    vld_1_r;

  logic signed [CRD_W-1:0] o_1 [3];
  logic signed [PNT_W-1:0] pnt [3];
  logic signed [PNT_W:0]   dst [3];
  logic [PNT_W:0]          dmag [3];
  logic                    far_nxt;

  logic [RAD_W-1:0]        a_2_r [3];
  logic signed [CRD_W-1:0] p_2_r [3];
  logic                    far_2_r;
  logic [T_W-1:0]          t_2_r;
  logic                    ok_2_r;
  logic                    vld_2_r;

  logic [R2_W-1:0]         sq_3_r [3];
  logic signed [CRD_W-1:0] p_3_r [3];
  logic                    far_3_r;
  logic [T_W-1:0]          t_3_r;
  logic                    ok_3_r;
  logic                    vld_3_r;

  logic [R2_W+1:0]         sq_sum;
  cap_res_t                res_r;

  always_comb begin
    d_v[0] = ray.d.x; d_v[1] = ray.d.y; d_v[2] = ray.d.z;
    c_v[0] = ctr.x;   c_v[1] = ctr.y;   c_v[2] = ctr.z;
    o_1[0] = o_1_r.x; o_1[1] = o_1_r.y; o_1[2] = o_1_r.z;
  end

  // stage 1: clamp t and scale the direction
  always_comb begin
    ti    = rsp.ov ? {1'b0, {QUO_W{1'b1}}} : {1'b0, rsp.q};
    t_nxt = (rsp.ov || (|rsp.q[QUO_W-1:T_W])) ? T_SAT : rsp.q[T_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_1_r <= 1'b0;
    end else if (en) begin
      vld_1_r <= rsp.vld;
      ok_1_r  <= rsp.ok;
      t_1_r   <= t_nxt;
      o_1_r   <= ray.o;
      for (int i = 0; i < 3; i++) begin
        prod_1_r[i] <= d_v[i] * ti;
      end
    end
  end

  // stage 2: hit point and distance from the cap centre per axis
  always_comb begin
    far_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      pnt[i]  = PNT_W'(o_1[i]) + PNT_W'(prod_1_r[i] >>> 16);
      dst[i]  = (PNT_W+1)'(pnt[i]) - (PNT_W+1)'(c_v[i]);
      dmag[i] = dst[i][PNT_W] ? (PNT_W+1)'(-dst[i]) : (PNT_W+1)'(dst[i]);
      if (dmag[i] > (PNT_W+1)'(radius)) begin
        far_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_2_r <= 1'b0;
    end else if (en) begin
      vld_2_r <= vld_1_r;
      ok_2_r  <= ok_1_r;
      t_2_r   <= t_1_r;
      far_2_r <= far_nxt;
      for (int i = 0; i < 3; i++) begin
        a_2_r[i] <= dmag[i][RAD_W-1:0];
        p_2_r[i] <= sat_crd(pnt[i]);
      end
    end
  end

  // stage 3: squares
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_3_r <= 1'b0;
    end else if (en) begin
      vld_3_r <= vld_2_r;
      ok_3_r  <= ok_2_r;
      t_3_r   <= t_2_r;
      far_3_r <= far_2_r;
      for (int i = 0; i < 3; i++) begin
        sq_3_r[i] <= R2_W'(a_2_r[i]) * R2_W'(a_2_r[i]);
        p_3_r[i]  <= p_2_r[i];
      end
    end
  end

  // stage 4: squared distance against squared radius
  assign sq_sum = (R2_W+2)'(sq_3_r[0]) + (R2_W+2)'(sq_3_r[1]) + (R2_W+2)'(sq_3_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.vld <= 1'b0;
    end else if (en) begin
      res_r.vld <= vld_3_r;
      res_r.hit <= ok_3_r && !far_3_r && (sq_sum <= (R2_W+2)'(r2));
      res_r.t   <= t_3_r;
      res_r.p.x <= p_3_r[0];
      res_r.p.y <= p_3_r[1];
      res_r.p.z <= p_3_r[2];
    end
  end

  assign res = res_r;

endmodule

/* sv/ray_cylinder_cap_intersect_core.sv */
// ---------------------------------------------------------------------------
// ray_cylinder_cap_intersect_core
// Ray against the two end caps of a cylinder, Q16.16. Near cap tested first;
// the first cap that hits is reported.
//
//   port      dir  transaction
//   in_ray    in   one ray: origin_x/y/z, dir_x/y/z
//   out_res   out  one result per ray: hit, which_cap, hit_t, point_x/y/z
//   cfg_*     in   register write: cfg_we, cfg_index, cfg_data
//
// one ray accepted per cycle while the skid register is empty; the depth is
// set by the 41-stage divider (one quotient bit per stage) between plane setup
// and the disk test. both caps run in parallel lanes.
// synchronous active-low reset clears valid bits and the configuration registers.
// a stall holds the whole pipeline; a skid register behind the output keeps
// in_ray.ready registered, and rays still enter while a result waits.
// ---------------------------------------------------------------------------
module ray_cylinder_cap_intersect_core import rcc_pkg::*; #(
  parameter int DENOM_EPSILON = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  rcc_ray_if.sink          in_ray,
  rcc_res_if.source        out_res,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam logic [EPS_W-1:0] EPS = EPS_W'(DENOM_EPSILON);

  typedef struct packed {
    logic           hit;
    logic           which_cap;
    logic [T_W-1:0] t;
    vec_crd_t       p;
  } res_pl_t;

  vec_crd_t                base_r;
  vec_dir_t                ax_r;
  logic [RAD_W-1:0]        radius_r;
  logic [T_W-1:0]          height_r;
  logic signed [DIR_W+CRD_W-1:0] axh_r [3];
  logic [R2_W-1:0]         r2_r;

  vec_ctr_t                ctr_near;
  vec_ctr_t                ctr_far;
  vec_nrm_t                nrm_near;
  vec_nrm_t                nrm_far;

  logic                    adv;
  logic                    vld_s1_r;
  ray_t                    ray_s1_r;
  ray_t                    ray_in;
  ray_t                    ray_dl_r [RAY_DLY];

  div_req_t                req_near, req_far;
  div_rsp_t                rsp_near, rsp_far;
  cap_res_t                res_near, res_far;

  res_pl_t                 res_nxt;
  res_pl_t                 out_r;
  res_pl_t                 skid_r;
  logic                    out_vld_r;
  logic                    skid_vld_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      ax_r.x   <= '0;
      ax_r.y   <= DIR_W'(65536);
      ax_r.z   <= '0;
      radius_r <= RAD_W'(65536);
      height_r <= T_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_X: base_r.x <= cfg_data;
        REG_BASE_Y: base_r.y <= cfg_data;
        REG_BASE_Z: base_r.z <= cfg_data;
        REG_AXIS_X: ax_r.x   <= cfg_data[DIR_W-1:0];
        REG_AXIS_Y: ax_r.y   <= cfg_data[DIR_W-1:0];
        REG_AXIS_Z: ax_r.z   <= cfg_data[DIR_W-1:0];
        REG_RADIUS: radius_r <= cfg_data[RAD_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[T_W-1:0];
        default: ;
      endcase
    end
  end

  // terms that depend on configuration only
  always_ff @(posedge clk) begin
    axh_r[0] <= ax_r.x * $signed({1'b0, height_r});
    axh_r[1] <= ax_r.y * $signed({1'b0, height_r});
    axh_r[2] <= ax_r.z * $signed({1'b0, height_r});
    r2_r     <= R2_W'(radius_r) * R2_W'(radius_r);
  end

  always_comb begin
    ctr_near.x = CTR_W'(base_r.x);
    ctr_near.y = CTR_W'(base_r.y);
    ctr_near.z = CTR_W'(base_r.z);
    ctr_far.x  = CTR_W'(base_r.x) + CTR_W'(axh_r[0] >>> 16);
    ctr_far.y  = CTR_W'(base_r.y) + CTR_W'(axh_r[1] >>> 16);
    ctr_far.z  = CTR_W'(base_r.z) + CTR_W'(axh_r[2] >>> 16);
    nrm_near.x = -NRM_W'(ax_r.x);
    nrm_near.y = -NRM_W'(ax_r.y);
    nrm_near.z = -NRM_W'(ax_r.z);
    nrm_far.x  = NRM_W'(ax_r.x);
    nrm_far.y  = NRM_W'(ax_r.y);
    nrm_far.z  = NRM_W'(ax_r.z);
  end

  // input register and ray delay line alongside the divider
  assign adv          = !skid_vld_r;
  assign in_ray.ready = adv;

  always_comb begin
    ray_in.o.x = in_ray.origin_x;
    ray_in.o.y = in_ray.origin_y;
    ray_in.o.z = in_ray.origin_z;
    ray_in.d.x = in_ray.dir_x;
    ray_in.d.y = in_ray.dir_y;
    ray_in.d.z = in_ray.dir_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_s1_r <= 1'b0;
    end else if (adv) begin
      vld_s1_r <= in_ray.valid;
      ray_s1_r <= ray_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ray_dl_r[0] <= ray_s1_r;
      for (int i = 1; i < RAY_DLY; i++) begin
        ray_dl_r[i] <= ray_dl_r[i-1];
      end
    end
  end

  // near cap lane
  rcc_cap_front u_front_near (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld_in(vld_s1_r), .ray(ray_s1_r),
    .nrm(nrm_near), .ctr(ctr_near), .eps(EPS), .req(req_near)
  );

  rcc_div u_div_near (
    .clk(clk), .rst_n(rst_n), .en(adv), .req(req_near), .rsp(rsp_near)
  );

  rcc_cap_back u_back_near (
    .clk(clk), .rst_n(rst_n), .en(adv), .rsp(rsp_near), .ray(ray_dl_r[RAY_DLY-1]),
    .ctr(ctr_near), .radius(radius_r), .r2(r2_r), .res(res_near)
  );

  // far cap lane
  rcc_cap_front u_front_far (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld_in(vld_s1_r), .ray(ray_s1_r),
    .nrm(nrm_far), .ctr(ctr_far), .eps(EPS), .req(req_far)
  );

  rcc_div u_div_far (
    .clk(clk), .rst_n(rst_n), .en(adv), .req(req_far), .rsp(rsp_far)
  );

  rcc_cap_back u_back_far (
    .clk(clk), .rst_n(rst_n), .en(adv), .rsp(rsp_far), .ray(ray_dl_r[RAY_DLY-1]),
    .ctr(ctr_far), .radius(radius_r), .r2(r2_r), .res(res_far)
  );

  // near cap wins whenever it hits
  always_comb begin
    res_nxt = '0;
    if (res_near.hit) begin
      res_nxt.hit = 1'b1;
      res_nxt.t   = res_near.t;
      res_nxt.p   = res_near.p;
    end else if (res_far.hit) begin
      res_nxt.hit       = 1'b1;
      res_nxt.which_cap = 1'b1;
      res_nxt.t         = res_far.t;
      res_nxt.p         = res_far.p;
    end
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_res.ready) begin
        out_r      <= skid_r;
        skid_vld_r <= 1'b0;
      end
    end else if (!out_vld_r || out_res.ready) begin
      out_vld_r <= res_near.vld;
      if (res_near.vld) begin
        out_r <= res_nxt;
      end
    end else if (res_near.vld) begin
      skid_r     <= res_nxt;
      skid_vld_r <= 1'b1;
    end
  end

  assign out_res.valid     = out_vld_r;
  assign out_res.hit       = out_r.hit;
  assign out_res.which_cap = out_r.which_cap;
  assign out_res.hit_t     = out_r.t;
  assign out_res.point_x   = out_r.p.x;
  assign out_res.point_y   = out_r.p.y;
  assign out_res.point_z   = out_r.p.z;

endmodule

/* test/tb_cap_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_cap_checker
// Watches the ray, result and register write ports of the cylinder cap
// intersection core, predicts each result from its own register copy and
// compares the results in order, field by field.
// ---------------------------------------------------------------------------
module tb_cap_checker import rcc_pkg::*; #(
  parameter int DENOM_EPSILON = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  rcc_ray_if               ray,
  rcc_res_if               res,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               fail_count,
  output int               pending
);

  typedef struct {
    logic                    hit;
    logic                    which_cap;
    logic [T_W-1:0]          hit_t;
    logic signed [CRD_W-1:0] px;
    logic signed [CRD_W-1:0] py;
    logic signed [CRD_W-1:0] pz;
  } cap_hit_t;

  localparam longint unsigned T_CLAMP = 64'd1 << 40;

  logic [CFG_W-1:0] shadow [8];
  cap_hit_t         hits_due [$];

  function automatic longint unsigned mag(input longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic logic [CRD_W-1:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[CRD_W-1:0];
  endfunction

  // plane hit with t >= 0, then the squared-radius disk test on the wide point
  function automatic bit disk_hit(input longint c [3], input longint n [3],
                                  input longint o [3], input longint d [3],
                                  input longint unsigned rad,
                                  output longint unsigned t_mag, output longint p [3]);
    longint          den, num, ti;
    longint unsigned tm, a, sum, r2;
    t_mag = 0;
    p = '{0, 0, 0};
    sum = 0;
    den = (n[0] * d[0] + n[1] * d[1] + n[2] * d[2]) >>> 16;
    if (!(mag(den) > DENOM_EPSILON) || den == 0) return 0;
    num = 0;
    for (int i = 0; i < 3; i++) num += (c[i] - o[i]) * n[i];
    if (num != 0 && ((num > 0) != (den > 0))) return 0;
    tm = mag(num) / mag(den);
    ti = (tm >= T_CLAMP) ? longint'(T_CLAMP - 1) : longint'(tm);
    for (int i = 0; i < 3; i++) p[i] = o[i] + ((d[i] * ti) >>> 16);
    for (int i = 0; i < 3; i++) begin
      a = mag(p[i] - c[i]);
      if (a > rad) return 0;
      sum += a * a;
    end
    r2 = rad * rad;
    if (sum > r2) return 0;
    t_mag = tm;
    return 1;
  endfunction

  function automatic cap_hit_t trace_caps();
    cap_hit_t        r;
    longint          o [3], d [3], base [3], ax [3], c [3], n [3], p [3];
    longint          height;
    longint unsigned rad, tm;
    bit              got;
    o[0] = longint'(ray.origin_x);
    o[1] = longint'(ray.origin_y);
    o[2] = longint'(ray.origin_z);
    d[0] = longint'(ray.dir_x);
    d[1] = longint'(ray.dir_y);
    d[2] = longint'(ray.dir_z);
    for (int i = 0; i < 3; i++) begin
      base[i] = longint'($signed(shadow[i]));
      ax[i]   = longint'($signed(shadow[3 + i][DIR_W-1:0]));
    end
    rad    = longint'(shadow[REG_RADIUS][RAD_W-1:0]);
    height = longint'(shadow[REG_HEIGHT][T_W-1:0]);
    for (int i = 0; i < 3; i++) begin
      c[i] = base[i];
      n[i] = -ax[i];
    end
    r = '{default: '0};
    got = disk_hit(c, n, o, d, rad, tm, p);
    if (!got) begin
      for (int i = 0; i < 3; i++) begin
        c[i] = base[i] + ((ax[i] * height) >>> 16);
        n[i] = ax[i];
      end
      got = disk_hit(c, n, o, d, rad, tm, p);
      r.which_cap = 1'b1;
    end
    if (!got) return '{default: '0};
    r.hit   = 1'b1;
    r.hit_t = (tm > 64'h7fffffff) ? T_SAT : tm[T_W-1:0];
    r.px    = sat32(p[0]);
    r.py    = sat32(p[1]);
    r.pz    = sat32(p[2]);
    return r;
  endfunction

  always @(posedge clk) begin
    cap_hit_t want;
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) shadow[i] <= '0;
      shadow[REG_AXIS_Y] <= 32'd65536;
      shadow[REG_RADIUS] <= 32'd65536;
      shadow[REG_HEIGHT] <= 32'd65536;
      hits_due.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) shadow[cfg_index] <= cfg_data;
      if (ray.valid && ray.ready) hits_due.push_back(trace_caps());
      if (res.valid && res.ready) begin
        if (hits_due.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = hits_due.pop_front();
          if (res.hit !== want.hit || res.which_cap !== want.which_cap ||
              res.hit_t !== want.hit_t || res.point_x !== want.px ||
              res.point_y !== want.py || res.point_z !== want.pz) begin
            fail_count <= fail_count + 1;
            if (res.hit !== want.hit)
              $error("hit: expected %0d, got %0d", want.hit, res.hit);
            if (res.which_cap !== want.which_cap)
              $error("which_cap: expected %0d, got %0d", want.which_cap, res.which_cap);
            if (res.hit_t !== want.hit_t)
              $error("hit_t: expected %0d, got %0d", want.hit_t, res.hit_t);
            if (res.point_x !== want.px)
              $error("point_x: expected %0d, got %0d", want.px, res.point_x);
            if (res.point_y !== want.py)
              $error("point_y: expected %0d, got %0d", want.py, res.point_y);
            if (res.point_z !== want.pz)
              $error("point_z: expected %0d, got %0d", want.pz, res.point_z);
          end
        end
      end
    end
  end

  always_comb pending = hits_due.size();

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus for the cylinder cap intersection core: directed rays at the reset
// cylinder and two extreme cylinders, then phases of aimed and raw random rays under
// several register settings and handshake idling patterns, with one long output stall.
// ---------------------------------------------------------------------------
module tb_top;
  import rcc_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  int               fail_count;
  int               pending;
  int               send_idle = 0;
  int               recv_idle = 0;
  bit               long_stall = 0;

  rcc_ray_if ray ();
  rcc_res_if res ();

  ray_cylinder_cap_intersect_core dut (
    .clk(clk), .rst_n(rst_n), .in_ray(ray.sink), .out_res(res.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tb_cap_checker chk (
    .clk(clk), .rst_n(rst_n), .ray(ray), .res(res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always #1 clk = ~clk;

  initial begin
    ray.valid = 1'b0;
    ray.origin_x = '0;
    ray.origin_y = '0;
    ray.origin_z = '0;
    ray.dir_x = '0;
    ray.dir_y = '0;
    ray.dir_z = '0;
    res.ready = 1'b0;
  end

  // receiver: random idling, plus one long hold-off while rays keep coming
  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (long_stall && !held) begin
        held = 1;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("ray_cylinder_cap_intersect_core regression: fail");
    $finish;
  end

  // cap geometry mirrored here only for aiming rays
  longint base_v [3];
  longint axis_v [3];
  longint height_v;
  longint radius_v;

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_cylinder(input longint bx, by, bz, input longint ax, ay, az,
                              input longint rad, hgt);
    // the last ray was already taken, stop offering it
    ray.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    write_reg(REG_BASE_X, bx[31:0]);
    write_reg(REG_BASE_Y, by[31:0]);
    write_reg(REG_BASE_Z, bz[31:0]);
    write_reg(REG_AXIS_X, ax[31:0]);
    write_reg(REG_AXIS_Y, ay[31:0]);
    write_reg(REG_AXIS_Z, az[31:0]);
    write_reg(REG_RADIUS, rad[31:0]);
    write_reg(REG_HEIGHT, hgt[31:0]);
    cfg_we <= 1'b0;
    base_v   = '{bx, by, bz};
    axis_v   = '{longint'($signed(ax[DIR_W-1:0])), longint'($signed(ay[DIR_W-1:0])),
                 longint'($signed(az[DIR_W-1:0]))};
    radius_v = rad & 64'h7fffffff;
    height_v = hgt & 64'h7fffffff;
  endtask

  task automatic send_ray(input longint ox, oy, oz, input longint dx, dy, dz);
    while ($urandom_range(99) < send_idle) begin
      ray.valid <= 1'b0;
      @(posedge clk);
    end
    ray.valid    <= 1'b1;
    ray.origin_x <= ox[CRD_W-1:0];
    ray.origin_y <= oy[CRD_W-1:0];
    ray.origin_z <= oz[CRD_W-1:0];
    ray.dir_x    <= dx[DIR_W-1:0];
    ray.dir_y    <= dy[DIR_W-1:0];
    ray.dir_z    <= dz[DIR_W-1:0];
    @(posedge clk);
    while (!ray.ready) @(posedge clk);
  endtask

  function automatic longint srand(input int bits);
    return longint'($signed({$urandom, $urandom})) >>> (64 - bits);
  endfunction

  // aim at a point near one cap centre, coming in roughly along +/- axis
  task automatic aimed_ray();
    longint c [3], tgt [3], d [3], k;
    bit far;
    far = $urandom_range(1);
    for (int i = 0; i < 3; i++)
      c[i] = base_v[i] + (far ? ((axis_v[i] * height_v) >>> 16) : 0);
    for (int i = 0; i < 3; i++) begin
      tgt[i] = c[i] + srand(18);
      d[i]   = axis_v[i] * ($urandom_range(1) ? 1 : -1);
      if ($urandom_range(3) == 0) d[i] += srand(13);
      if (d[i] > 65536) d[i] = 65536;
      if (d[i] < -65536) d[i] = -65536;
    end
    k = $urandom_range(3) == 0 ? srand(24) : longint'($urandom_range(1 << 22));
    send_ray(tgt[0] - ((d[0] * k) >>> 16), tgt[1] - ((d[1] * k) >>> 16),
             tgt[2] - ((d[2] * k) >>> 16), d[0], d[1], d[2]);
  endtask

  task automatic raw_ray();
    send_ray(srand(32), srand(32), srand(32), srand(18), srand(18), srand(18));
  endtask

  task automatic random_cylinder();
    longint ax [3];
    int pick;
    pick = $urandom_range(3);
    ax = '{0, 0, 0};
    case (pick)
      0: ax[$urandom_range(2)] = $urandom_range(1) ? 65536 : -65536;
      1: begin
        ax[0] = $urandom_range(1) ? 46341 : -46341;
        ax[2] = $urandom_range(1) ? 46341 : -46341;
      end
      2: ax = '{37837, -37837, 37837};
      default: ax = '{srand(18), srand(18), srand(18)};
    endcase
    set_cylinder(srand(22), srand(22), srand(22), ax[0], ax[1], ax[2],
                 $urandom_range(1 << 21), $urandom_range(1 << 22));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    base_v = '{0, 0, 0};
    axis_v = '{0, 65536, 0};
    radius_v = 65536;
    height_v = 65536;

    // reset cylinder: near cap, far cap from inside and outside, misses
    recv_idle = 0;
    send_ray(0, -65536, 0, 0, 65536, 0);
    send_ray(0, 131072, 0, 0, -65536, 0);
    send_ray(0, 32768, 0, 0, 65536, 0);
    send_ray(0, 32768, 0, 0, -65536, 0);
    send_ray(65536, -65536, 0, 0, 65536, 0);
    send_ray(65537, -65536, 0, 0, 65536, 0);
    send_ray(0, -65536, 0, 65536, 0, 0);
    send_ray(0, -65536, 0, 0, -65536, 0);
    send_ray(0, -65536, 0, 0, 1, 0);
    send_ray(0, -65536, 0, 0, 2, 0);
    send_ray(0, -65536, 0, 0, 131071, 0);
    send_ray(0, 0, 0, 0, 65536, 0);
    send_ray(0, -2147483648, 0, 0, 65536, 0);
    send_ray(2147483647, 2147483647, 2147483647, 131071, 131071, 131071);
    send_ray(-2147483648, -2147483648, -2147483648, -131072, -131072, -131072);
    send_ray(0, -2147483648, 0, 0, 3, 0);

    // extremes: huge radius and height so t and the point saturate, then a zero-size cylinder
    set_cylinder(2147483647, -2147483648, 0, 0, -65536, 0, 2147483647, 2147483647);
    send_ray(0, 0, 0, 0, 65536, 0);
    send_ray(-2147483648, 2147483647, 2147483647, 0, -65536, 0);
    send_ray(2147483647, 2147483647, -2147483648, 0, 2, 0);
    send_ray(0, -2147483648, 0, 65536, 0, 0);
    set_cylinder(-2147483648, 2147483647, -2147483648, -131072, 131071, -65536, 0, 0);
    send_ray(-2147483648, 2147483647, -2147483648, 0, 65536, 0);
    send_ray(0, 0, 0, 131071, -131072, 65536);

    for (int phase = 0; phase < 8; phase++) begin
      random_cylinder();
      if (phase < 3) begin
        send_idle = 22;
        recv_idle = 69;
      end else if (phase < 6) begin
        send_idle = 69;
        recv_idle = 22;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (phase == 6) long_stall = 1;
      for (int n = 0; n < 205; n++) begin
        if ($urandom_range(9) < 8) aimed_ray();
        else raw_ray();
      end
    end
    ray.valid <= 1'b0;
    send_idle = 0;
    recv_idle = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0)
      $display("ray_cylinder_cap_intersect_core regression: pass");
    else
      $display("ray_cylinder_cap_intersect_core regression: fail");
    $finish;
  end

endmodule

/* ray_cylinder_cap_intersect_core.f */
sv/rcc_pkg.sv
sv/rcc_ray_if.sv
sv/rcc_res_if.sv
sv/rcc_cap_front.sv
sv/rcc_div.sv
sv/rcc_cap_back.sv
sv/ray_cylinder_cap_intersect_core.sv
test/tb_cap_checker.sv
test/tb_top.sv
